/* rtl/core/lsft_pkg.sv */
// Package for the LED scanner core: sizes, register map, state and result types.
// No dependencies; imported by every module of the core.
package lsft_pkg;

    // Strip length and derived widths
    localparam int LED_COUNT = 8;
    localparam int IDX_W     = $clog2(LED_COUNT);
    localparam int LEDS_W    = 8;
    localparam int POS_W     = 3;

    // Field widths
    localparam int HOLD_W    = 20;
    localparam int SLOT_W    = 16;
    localparam int SPEED_W   = 3;
    localparam int ELAPSED_W = 21;

    // Reset values of the configuration registers
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(400000);
    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(5000);

    // Register map (selected by paddr[2])
    localparam int ADDR_W = 3;
    typedef enum logic {
        REG_HOLD = 1'b0,
        REG_SLOT = 1'b1
    } lsft_reg_t;

    // Scanner state carried between ticks
    typedef struct packed {
        logic [IDX_W-1:0]     step_index;
        logic                 direction;
        logic [1:0]           slot_in_frame;
        logic [ELAPSED_W-1:0] elapsed_time;
    } lsft_state_t;

    // Result of one tick
    typedef struct packed {
        logic [LEDS_W-1:0] leds;
        logic [POS_W-1:0]  head_position;
        logic              sweep_direction;
    } lsft_result_t;

    // Configuration values seen by the step logic
    typedef struct packed {
        logic [HOLD_W-1:0] hold_us;
        logic [SLOT_W-1:0] slot_us;
    } lsft_cfg_t;

endpackage

/* rtl/core/lsft_regs.sv */
// APB-style configuration registers (hold_us, slot_us) of the scanner core.
// Depends on lsft_pkg.
module lsft_regs
    import lsft_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output lsft_cfg_t         cfg
);

    logic [HOLD_W-1:0] hold_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              wr_en;
    lsft_reg_t         sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = lsft_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= HOLD_RESET;
            slot_reg <= SLOT_RESET;
        end else if (wr_en) begin
            case (sel)
                REG_HOLD: hold_reg <= pwdata[HOLD_W-1:0];
                REG_SLOT: slot_reg <= pwdata[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_HOLD: prdata = 32'(hold_reg);
            REG_SLOT: prdata = 32'(slot_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.hold_us = hold_reg;
    assign cfg.slot_us = slot_reg;

endmodule

/* rtl/core/lsft_step.sv */
// One-tick update: dwell check, head advance, tail pattern, elapsed time.
// Purely combinational; depends on lsft_pkg.
module lsft_step
    import lsft_pkg::*;
(
    input  lsft_state_t        cur,
    input  lsft_cfg_t          cfg,
    input  logic [SPEED_W-1:0] speed,
    output lsft_state_t        nxt,
    output lsft_result_t       res
);

    logic [HOLD_W-1:0]    dwell;
    logic                 advance;
    logic                 at_end;
    logic [IDX_W-1:0]     si;
    logic [IDX_W-1:0]     si_n;
    logic                 dir_n;
    logic [IDX_W-1:0]     pos0, pos1, pos2;
    logic [IDX_W-1:0]     led0, led1, led2;
    logic                 tail1, tail2;
    logic [ELAPSED_W-1:0] el_base;
    logic [ELAPSED_W:0]   el_sum;
    logic [LEDS_W-1:0]    pattern;

    // step_index never leaves 0..LED_COUNT-1, but wrap anyway
    assign si      = (32'(cur.step_index) >= LED_COUNT) ? '0 : cur.step_index;
    assign dwell   = cfg.hold_us >> speed;
    assign advance = (cur.slot_in_frame == 2'd0) && (cur.elapsed_time != '0)
                     && (cur.elapsed_time >= ELAPSED_W'(dwell));
    assign at_end  = (32'(si) + 32'd1) >= LED_COUNT;
    assign si_n    = !advance ? si : (at_end ? '0 : si + IDX_W'(1));
    assign dir_n   = cur.direction ^ (advance && at_end);

    assign pos0 = si_n;
    assign pos1 = si_n - IDX_W'(1);
    assign pos2 = si_n - IDX_W'(2);
    assign led0 = dir_n ? IDX_W'(LED_COUNT - 1) - pos0 : pos0;
    assign led1 = dir_n ? IDX_W'(LED_COUNT - 1) - pos1 : pos1;
    assign led2 = dir_n ? IDX_W'(LED_COUNT - 1) - pos2 : pos2;

    assign tail1 = (cur.slot_in_frame < 2'd2) && (si_n >= IDX_W'(1));
    assign tail2 = (cur.slot_in_frame == 2'd0) && (si_n >= IDX_W'(2));

    always_comb begin
        for (int k = 0; k < LEDS_W; k++) begin
            if (k < LED_COUNT) begin
                pattern[k] = (led0 == IDX_W'(k))
                             || (tail1 && (led1 == IDX_W'(k)))
                             || (tail2 && (led2 == IDX_W'(k)));
            end else begin
                pattern[k] = 1'b0;
            end
        end
    end

    // Saturating elapsed-time accumulate
    assign el_base = advance ? '0 : cur.elapsed_time;
    assign el_sum  = (ELAPSED_W+1)'(el_base) + (ELAPSED_W+1)'(cfg.slot_us);

    assign nxt.step_index    = si_n;
    assign nxt.direction     = dir_n;
    assign nxt.slot_in_frame = cur.slot_in_frame + 2'd1;
    assign nxt.elapsed_time  = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];

    assign res.leds            = pattern;
    assign res.head_position   = POS_W'(led0);
    assign res.sweep_direction = dir_n;

endmodule

/* rtl/core/led_scanner_with_fading_tail_core.sv */
// Larson-style LED scanner with a fading tail, one result per tick transaction.
// The result of an accepted tick is in the output register in the cycle after acceptance.
// Throughput: 1 transaction per cycle while m_ready is high; set by the single state/output register stage.
// s_ready is high whenever the output register is empty or being drained.
// Reset (aresetn low, synchronous): head at LED 0, forward sweep, slot 0,
// elapsed time 0, output empty, hold_us = 400000, slot_us = 5000.
module led_scanner_with_fading_tail_core
    import lsft_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // tick input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [SPEED_W-1:0] s_speed,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEDS_W-1:0]  m_leds,
    output logic [POS_W-1:0]   m_head_position,
    output logic               m_sweep_direction
);

    lsft_cfg_t    cfg;
    lsft_state_t  state_reg, state_next;
    lsft_result_t res_reg, res_next;
    logic         m_valid_reg;
    logic         s_fire;

    // Configuration registers
    lsft_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Tick update logic: current state + speed -> next state + result
    lsft_step u_step (
        .cur   (state_reg),
        .cfg   (cfg),
        .speed (s_speed),
        .nxt   (state_next),
        .res   (res_next)
    );

    // Accept a new transaction whenever the output slot frees up this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Scanner state advances only on an accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Output register: valid is control, payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_leds            = res_reg.leds;
    assign m_head_position   = res_reg.head_position;
    assign m_sweep_direction = res_reg.sweep_direction;

`ifndef SYNTH
    // Head stays inside the strip
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(state_reg.step_index) < LED_COUNT)
        else $error("step_index out of range");

    // Every accepted tick moves one slot forward in the frame
    a_slot_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg.slot_in_frame == $past(state_reg.slot_in_frame) + 2'd1)
        else $error("slot counter did not advance");

    // Head only moves on the first slot of a frame
    a_move_at_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg.slot_in_frame != 2'd0) |=>
            $stable(state_reg.step_index) && $stable(state_reg.direction))
        else $error("head moved mid-frame");

    // State is frozen without an accepted tick
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(state_reg))
        else $error("state changed without a tick");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench for led_scanner_with_fading_tail_core: drives tick transactions and APB writes.
// Results are checked against a scanner predictor in a small scoreboard class.
// Depends on lsft_pkg and the core RTL only.
module testbench;
    import lsft_pkg::*;

    localparam int unsigned ELAPSED_MAX     = (1 << ELAPSED_W) - 1;
    localparam int unsigned HOLD_MAX        = (1 << HOLD_W) - 1;
    localparam int unsigned SLOT_MAX        = (1 << SLOT_W) - 1;
    localparam int          ROUNDS          = 10;
    localparam int          TICKS_PER_ROUND = 65;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          REPORT_LIMIT    = 10;

    // Scanner predictor plus the queue of frames still owed by the core.
    class scanner_tracker;
        int unsigned  hold_us;
        int unsigned  slot_us;
        int unsigned  step_index;
        bit           direction;
        int unsigned  slot_in_frame;
        int unsigned  elapsed_time;
        lsft_result_t frames_due[$];
        int unsigned  failures;
        int unsigned  frames_seen;

        function new();
            hold_us       = 32'(HOLD_RESET);
            slot_us       = 32'(SLOT_RESET);
            step_index    = 0;
            direction     = 1'b0;
            slot_in_frame = 0;
            elapsed_time  = 0;
            failures      = 0;
            frames_seen   = 0;
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("MISMATCH: %s", what);
            end
        endfunction

        // LED index of the element 'back' steps behind the head
        function int unsigned led_behind(int unsigned back);
            int unsigned pos;
            pos = step_index - back;
            return direction ? LED_COUNT - 1 - pos : pos;
        endfunction

        function logic [LEDS_W-1:0] led_mask(int unsigned back);
            int unsigned idx;
            idx = led_behind(back);
            return (idx < LEDS_W && idx < LED_COUNT) ? LEDS_W'(1) << idx : '0;
        endfunction

        function void note_tick(logic [SPEED_W-1:0] speed);
            lsft_result_t frame;
            // dwell check only at frame start, and only once some time has passed
            if (slot_in_frame == 0 && elapsed_time != 0 && elapsed_time >= (hold_us >> speed)) begin
                elapsed_time = 0;
                if (step_index + 1 >= LED_COUNT) begin
                    step_index = 0;
                    direction  = !direction;
                end else begin
                    step_index++;
                end
            end
            // tail fades: one behind in slots 0-1, two behind in slot 0 only
            frame.leds = led_mask(0);
            if (slot_in_frame < 2 && step_index >= 1) begin
                frame.leds |= led_mask(1);
            end
            if (slot_in_frame == 0 && step_index >= 2) begin
                frame.leds |= led_mask(2);
            end
            frame.head_position   = POS_W'(led_behind(0));
            frame.sweep_direction = direction;
            if (elapsed_time + slot_us > ELAPSED_MAX) begin
                elapsed_time = ELAPSED_MAX;
            end else begin
                elapsed_time += slot_us;
            end
            slot_in_frame = (slot_in_frame + 1) % 4;
            frames_due.push_back(frame);
        endfunction

        function void check_frame(logic [LEDS_W-1:0] leds, logic [POS_W-1:0] head,
                                  logic dir);
            lsft_result_t want;
            frames_seen++;
            if (frames_due.size() == 0) begin
                flag($sformatf("result %0d arrived with no tick outstanding", frames_seen));
                return;
            end
            want = frames_due.pop_front();
            if (leds !== want.leds) begin
                flag($sformatf("result %0d leds: expected %02h got %02h",
                               frames_seen, want.leds, leds));
            end
            if (head !== want.head_position) begin
                flag($sformatf("result %0d head_position: expected %0d got %0d",
                               frames_seen, want.head_position, head));
            end
            if (dir !== want.sweep_direction) begin
                flag($sformatf("result %0d sweep_direction: expected %0d got %0d",
                               frames_seen, want.sweep_direction, dir));
            end
        endfunction
    endclass

    // DUT-facing signals; every input starts at a known value
    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid  = 1'b0;
    logic                s_ready;
    logic [SPEED_W-1:0]  s_speed  = '0;
    logic                m_valid;
    logic                m_ready  = 1'b0;
    logic [LEDS_W-1:0]   m_leds;
    logic [POS_W-1:0]    m_head_position;
    logic                m_sweep_direction;

    scanner_tracker tracker = new();

    // Traffic shaping knobs, set per round by the stimulus process
    bit sender_steady    = 1'b0;
    bit sink_steady      = 1'b0;
    bit hold_off_pending = 1'b0;

    led_scanner_with_fading_tail_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_speed           (s_speed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_leds            (m_leds),
        .m_head_position   (m_head_position),
        .m_sweep_direction (m_sweep_direction)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor: values read here are the pre-edge ones, since all drivers use NBAs.
    // The input is noted before the output is checked so same-edge order never matters.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tracker.note_tick(s_speed);
        end
        if (aresetn && m_valid && m_ready) begin
            tracker.check_frame(m_leds, m_head_position, m_sweep_direction);
        end
    end

    // Idle lengths: mostly short, now and then long
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // One tick transaction; valid stays up and the payload stays put until accepted.
    // Valid is only dropped when a gap follows, so back-to-back ticks keep it high.
    task automatic send_tick(logic [SPEED_W-1:0] speed);
        s_valid <= 1'b1;
        s_speed <= speed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!sender_steady && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    // APB read with a setup and an access cycle; prdata is taken at the access edge
    task automatic read_register(lsft_reg_t sel, int unsigned want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want) begin
            tracker.flag($sformatf("register %s read: expected %0d got %0d",
                                   sel.name(), want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write, then a back-to-back read of the same register
    task automatic write_register(lsft_reg_t sel, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (sel == REG_HOLD) begin
            tracker.hold_us = value;
        end else begin
            tracker.slot_us = value;
        end
        read_register(sel, value);
    endtask

    task automatic apply_settings(int unsigned hold_val, int unsigned slot_val);
        write_register(REG_HOLD, hold_val);
        write_register(REG_SLOT, slot_val);
    endtask

    // Drop valid and wait until every tick has produced its frame. The extra
    // edge lets the monitor log a tick accepted at this very edge; the tail
    // covers the output register of the core.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.frames_due.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Result sink: random stalls, steady stretches, and one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (sink_steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned hold_val;
        int unsigned slot_val;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values of both registers
        read_register(REG_HOLD, 32'(HOLD_RESET));
        read_register(REG_SLOT, 32'(SLOT_RESET));

        // Every speed code at the reset settings
        for (int sp = 0; sp < 8; sp++) begin
            send_tick(SPEED_W'(sp));
        end

        // Near-zero dwell: smallest hold with the largest slot moves one step per frame,
        // so the tail grows in behind the head at the start of the sweep
        wait_drained();
        apply_settings(1, SLOT_MAX);
        for (int i = 0; i < 12; i++) begin
            send_tick((i % 2 == 0) ? SPEED_W'(0) : SPEED_W'(7));
        end

        // Zero slot time: one last step once the time check passes, then the head sticks
        wait_drained();
        apply_settings(1, 0);
        for (int i = 0; i < 6; i++) begin
            send_tick(SPEED_W'(7));
        end

        // Random rounds: extremes, then one free pick, then hold picked as a modest multiple of
        // slot so the head keeps moving and the sweep turns around often
        for (int r = 0; r < ROUNDS; r++) begin
            wait_drained();
            case (r)
                0: begin
                    hold_val = HOLD_MAX;
                    slot_val = 1;
                end
                1: begin
                    hold_val = 1;
                    slot_val = SLOT_MAX;
                end
                2: begin
                    hold_val = HOLD_MAX;
                    slot_val = SLOT_MAX;
                end
                3: begin
                    hold_val = $urandom_range(1, HOLD_MAX);
                    slot_val = $urandom_range(1, SLOT_MAX);
                end
                default: begin
                    slot_val = $urandom_range(0, 1) ? $urandom_range(1, SLOT_MAX)
                                                    : $urandom_range(1, 255);
                    hold_val = slot_val * $urandom_range(0, 40) + $urandom_range(0, slot_val);
                    if (hold_val > HOLD_MAX) begin
                        hold_val = HOLD_MAX;
                    end
                    if (hold_val == 0) begin
                        hold_val = 1;
                    end
                end
            endcase
            apply_settings(hold_val, slot_val);

            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            if (r == 2) begin
                // back-pressure: sink holds off while ticks keep coming
                sender_steady    = 1'b1;
                hold_off_pending = 1'b1;
            end
            for (int i = 0; i < TICKS_PER_ROUND; i++) begin
                send_tick(SPEED_W'($urandom_range(0, 7)));
            end
        end

        wait_drained();
        repeat (3) @(posedge aclk);
        if (tracker.failures == 0) begin
            $display("led_scanner_with_fading_tail_core test passed");
        end else begin
            $display("led_scanner_with_fading_tail_core test failed");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #(5_000_000);
        $display("led_scanner_with_fading_tail_core test failed");
        $finish;
    end

endmodule
